### src/sbt_pkg.sv
`timescale 1ns / 1ps

package sbt_pkg;

    // command codes
    localparam logic OP_SET   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // breakpoint instruction halfword
    localparam logic [15:0] BKPT_HALFWORD = 16'hBE00;

    // guest memory map
    localparam logic [31:0] RAM_WIN_LO   = 32'h1000_0000;
    localparam logic [31:0] RAM_WIN_HI   = 32'h1000_2000;
    localparam int          RAM_WIN_BITS = 13;

    // config port
    localparam int   CFG_ADDR_W     = 3;
    localparam logic REG_FLASH_BASE = 1'b0;
    localparam logic REG_RAM_BASE   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // one table entry as stored in the memory
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] saved;
    } entry_t;

    // table strobes from the sequencer
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_en;
    } tbl_cmd_t;

endpackage

### src/sbt_if.sv
`timescale 1ns / 1ps

// command channel
interface sbt_cmd_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] guest_addr;
    logic [15:0] current_halfword;

    modport source (output valid, output opcode, output guest_addr,
                    output current_halfword, input ready);
    modport sink   (input valid, input opcode, input guest_addr,
                    input current_halfword, output ready);
endinterface

// response channel
interface sbt_rsp_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [15:0] mem_data;

    modport source (output valid, output ok, output mem_write,
                    output mem_address, output mem_data, input ready);
    modport sink   (input valid, input ok, input mem_write,
                    input mem_address, input mem_data, output ready);
endinterface

### src/software_breakpoint_table_core.sv
`timescale 1ns / 1ps

// Channel   Role      Word
// -------   -------   ----------------------------------------------------
// cmd       sink      opcode, guest_addr, current_halfword
// rsp       source    ok, mem_write, mem_address, mem_data
// APB       slave     flash_base at 0x0, ram_base at 0x4 (32-bit)
//
// A command is accepted and translated in ST_IDLE. ST_SCAN then reads the entry
// memory one entry per cycle through the single read port, each read registered
// before the compare, and stops early on a hit; a miss reads every entry. ST_DONE
// updates the table and loads the response register.
// Reset clears the used flags, base registers and control; entry contents
// are left as they are. A stalled rsp holds the finished word; the next cmd
// word is still taken and waits in the update step until the register frees.
module software_breakpoint_table_core
#(
    parameter int ENTRIES = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    sbt_cmd_if.sink                        cmd,
    sbt_rsp_if.source                      rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sbt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    sbt_pkg::state_t   state_reg;
    sbt_pkg::state_t   state_next;
    sbt_pkg::tbl_cmd_t tbl_cmd;
    sbt_pkg::entry_t   rd_data;
    sbt_pkg::entry_t   wr_data;

    // captured command
    logic              op_reg;
    logic [31:0]       addr_reg;
    logic [15:0]       half_reg;
    logic [31:0]       host_addr;

    // scan pipeline: issue counter and compare stage
    logic [CNT_W-1:0]  iss_reg;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              match;
    logic              last;

    // lookup result
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [15:0]       saved_reg;

    // table status
    logic [ENTRIES-1:0] used_vec;
    logic [IDX_W-1:0]   free_idx;
    logic               full;
    logic [IDX_W-1:0]   wr_idx;

    // response register
    logic              rsp_valid_reg;
    logic              rsp_ok_reg;
    logic              rsp_write_reg;
    logic [31:0]       rsp_addr_reg;
    logic [15:0]       rsp_data_reg;
    logic              out_free;
    logic              accept;
    logic              finish;

    sbt_xlate u_xlate
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .guest_addr (cmd.guest_addr),
        .host_addr  (host_addr)
    );

    sbt_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (tbl_cmd),
        .rd_idx   (iss_reg[IDX_W-1:0]),
        .wr_idx   (wr_idx),
        .wr_data  (wr_data),
        .rd_data  (rd_data),
        .used     (used_vec),
        .free_idx (free_idx),
        .full     (full)
    );

    assign pready   = 1'b1;
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign accept   = cmd.valid && cmd.ready;

    // compare stage sees the entry read in the previous cycle
    assign match = cmp_vld_reg && used_vec[cmp_idx_reg] && (rd_data.addr == addr_reg);
    assign last  = cmp_idx_reg == IDX_W'(ENTRIES - 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbt_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = sbt_pkg::ST_SCAN;
                end
            end
            sbt_pkg::ST_SCAN:
            begin
                if (match || (cmp_vld_reg && last))
                begin
                    state_next = sbt_pkg::ST_DONE;
                end
            end
            sbt_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = sbt_pkg::ST_IDLE;
                end
            end
            default: state_next = sbt_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        cmd.ready      = 1'b0;
        tbl_cmd.rd_en  = 1'b0;
        tbl_cmd.wr_en  = 1'b0;
        tbl_cmd.clr_en = 1'b0;
        finish         = 1'b0;
        unique case (state_reg)
            sbt_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            sbt_pkg::ST_SCAN:
            begin
                tbl_cmd.rd_en = iss_reg < CNT_W'(ENTRIES);
            end
            sbt_pkg::ST_DONE:
            begin
                finish         = out_free;
                // new set takes the lowest free entry; clear frees the hit
                tbl_cmd.wr_en  = out_free && (op_reg == sbt_pkg::OP_SET) && !hit_reg && !full;
                tbl_cmd.clr_en = out_free && (op_reg == sbt_pkg::OP_CLEAR) && hit_reg;
            end
            default: ;
        endcase
    end

    assign wr_idx        = tbl_cmd.clr_en ? hit_idx_reg : free_idx;
    assign wr_data.addr  = addr_reg;
    assign wr_data.saved = half_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sbt_pkg::ST_IDLE;
            iss_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                iss_reg     <= '0;
                cmp_vld_reg <= 1'b0;
                hit_reg     <= 1'b0;
            end
            else if (state_reg == sbt_pkg::ST_SCAN)
            begin
                if (tbl_cmd.rd_en)
                begin
                    iss_reg <= iss_reg + CNT_W'(1);
                end
                cmp_vld_reg <= tbl_cmd.rd_en;
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    // payload captures, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= cmd.opcode;
            addr_reg <= host_addr;
            half_reg <= cmd.current_halfword;
        end
        if (state_reg == sbt_pkg::ST_SCAN)
        begin
            cmp_idx_reg <= iss_reg[IDX_W-1:0];
            if (match)
            begin
                hit_idx_reg <= cmp_idx_reg;
                saved_reg   <= rd_data.saved;
            end
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            rsp_addr_reg <= addr_reg;
            if (op_reg == sbt_pkg::OP_SET)
            begin
                rsp_ok_reg    <= hit_reg || !full;
                rsp_write_reg <= tbl_cmd.wr_en;
                rsp_data_reg  <= tbl_cmd.wr_en ? sbt_pkg::BKPT_HALFWORD : 16'h0000;
            end
            else
            begin
                rsp_ok_reg    <= hit_reg;
                rsp_write_reg <= hit_reg;
                rsp_data_reg  <= hit_reg ? saved_reg : 16'h0000;
            end
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.ok          = rsp_ok_reg;
    assign rsp.mem_write   = rsp_write_reg;
    assign rsp.mem_address = rsp_addr_reg;
    assign rsp.mem_data    = rsp_data_reg;

`ifndef NO_ASSERTIONS
    a_wr_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(tbl_cmd.wr_en && tbl_cmd.clr_en))
        else $error("table write and clear in the same cycle");

    a_wr_free: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_cmd.wr_en |-> !used_vec[wr_idx])
        else $error("new breakpoint written over a used entry");

    a_clr_used: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_cmd.clr_en |-> used_vec[wr_idx])
        else $error("clear of an entry that is not in use");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == sbt_pkg::ST_SCAN) && (iss_reg == '0))
        else $error("accepted command did not start a scan");

    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_write_reg) |-> rsp_ok_reg)
        else $error("memory write reported on a failed command");
`endif

endmodule

### src/sbt_xlate.sv
`timescale 1ns / 1ps

// Base registers and guest-to-host address translation.
module sbt_xlate
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sbt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    input  logic [31:0]                    guest_addr,
    output logic [31:0]                    host_addr
);

    logic [31:0] flash_base_reg;
    logic [31:0] ram_base_reg;
    logic        wr_stb;
    logic        in_flash;
    logic        in_ram;
    logic [31:0] base;
    logic [31:0] offs;

    assign wr_stb = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_base_reg <= '0;
            ram_base_reg   <= '0;
        end
        else if (wr_stb)
        begin
            unique case (paddr[2])
                sbt_pkg::REG_FLASH_BASE: flash_base_reg <= pwdata;
                sbt_pkg::REG_RAM_BASE:   ram_base_reg   <= pwdata;
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            sbt_pkg::REG_FLASH_BASE: prdata = flash_base_reg;
            sbt_pkg::REG_RAM_BASE:   prdata = ram_base_reg;
            default:                 prdata = '0;
        endcase
    end

    // one adder: flash offset is the whole address, RAM offset the window bits
    assign in_flash = guest_addr < sbt_pkg::RAM_WIN_LO;
    assign in_ram   = !in_flash && (guest_addr < sbt_pkg::RAM_WIN_HI);
    assign base     = in_flash ? flash_base_reg : ram_base_reg;
    assign offs     = in_flash ? guest_addr
                               : 32'(guest_addr[sbt_pkg::RAM_WIN_BITS-1:0]);
    assign host_addr = (in_flash || in_ram) ? (base + offs) : guest_addr;

endmodule

### src/sbt_table.sv
`timescale 1ns / 1ps

// Entry memory (address + saved halfword) with per-entry used flags.
module sbt_table
#(
    parameter int ENTRIES = 8,
    parameter int IDX_W   = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sbt_pkg::tbl_cmd_t    cmd,
    input  logic [IDX_W-1:0]     rd_idx,
    input  logic [IDX_W-1:0]     wr_idx,
    input  sbt_pkg::entry_t      wr_data,
    output sbt_pkg::entry_t      rd_data,
    output logic [ENTRIES-1:0]   used,
    output logic [IDX_W-1:0]     free_idx,
    output logic                 full
);

    sbt_pkg::entry_t    mem [ENTRIES];
    sbt_pkg::entry_t    rd_data_reg;
    logic [ENTRIES-1:0] used_reg;
    logic [ENTRIES-1:0] used_next;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (cmd.wr_en)
        begin
            used_next[wr_idx] = 1'b1;
        end
        if (cmd.clr_en)
        begin
            used_next[wr_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    // lowest free entry
    always_comb
    begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign full    = &used_reg;
    assign used    = used_reg;
    assign rd_data = rd_data_reg;

endmodule

### tb/tb_software_breakpoint_table_core.sv
`timescale 1ns / 1ps

module tb_software_breakpoint_table_core;

    // register byte addresses on the config port
    localparam logic [sbt_pkg::CFG_ADDR_W-1:0] FLASH_BASE_ADDR =
        {sbt_pkg::REG_FLASH_BASE, 2'b00};
    localparam logic [sbt_pkg::CFG_ADDR_W-1:0] RAM_BASE_ADDR =
        {sbt_pkg::REG_RAM_BASE, 2'b00};

    localparam int BP_SLOTS  = 8;
    localparam int POOL_SIZE = 12;

    // one command word and one response word
    typedef struct packed {
        logic        opcode;
        logic [31:0] guest_addr;
        logic [15:0] current_halfword;
    } bp_cmd_t;

    typedef struct packed {
        logic        ok;
        logic        mem_write;
        logic [31:0] mem_address;
        logic [15:0] mem_data;
    } bp_rsp_t;

    logic clk;
    logic rst_n;

    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [sbt_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    sbt_cmd_if cmd_ch ();
    sbt_rsp_if rsp_ch ();

    software_breakpoint_table_core #(
        .ENTRIES (BP_SLOTS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the block: base registers and breakpoint table
    // ------------------------------------------------------------------
    logic [31:0] shadow_flash_base;
    logic [31:0] shadow_ram_base;
    logic [31:0] bp_addr  [BP_SLOTS];
    logic [15:0] bp_saved [BP_SLOTS];
    logic        bp_used  [BP_SLOTS];

    // responses still owed by the block, oldest first
    bp_rsp_t pending_rsp_q[$];

    int  mismatches = 0;
    bit  calm       = 1'b0;   // no new random stalls or gaps on either side while set
    int  stall_left = 0;

    // guest to host address mapping; sums wrap at 32 bits
    function automatic logic [31:0] host_of(logic [31:0] guest);
        if (guest < sbt_pkg::RAM_WIN_LO)
            return shadow_flash_base + guest;
        else if (guest < sbt_pkg::RAM_WIN_HI)
            return shadow_ram_base + (guest - sbt_pkg::RAM_WIN_LO);
        else
            return guest;
    endfunction

    // Works out the response to one command and updates the shadow table.
    function automatic bp_rsp_t apply_breakpoint_cmd(bp_cmd_t c);
        bp_rsp_t r;
        logic [31:0] host;
        int hit;
        int slot;
        host          = host_of(c.guest_addr);
        r             = '0;
        r.mem_address = host;
        hit           = -1;
        slot          = -1;
        // lowest numbered live match wins
        for (int i = 0; i < BP_SLOTS; i++)
            if (hit < 0 && bp_used[i] && bp_addr[i] == host)
                hit = i;
        if (c.opcode == sbt_pkg::OP_SET)
        begin
            if (hit >= 0)
            begin
                // already present: no memory write
                r.ok = 1'b1;
            end
            else
            begin
                for (int i = 0; i < BP_SLOTS; i++)
                    if (slot < 0 && !bp_used[i])
                        slot = i;
                if (slot >= 0)
                begin
                    bp_addr[slot]  = host;
                    bp_saved[slot] = c.current_halfword;
                    bp_used[slot]  = 1'b1;
                    r.ok           = 1'b1;
                    r.mem_write    = 1'b1;
                    r.mem_data     = sbt_pkg::BKPT_HALFWORD;
                end
                // table full: ok stays low
            end
        end
        else if (hit >= 0)
        begin
            // clear of a live entry restores the saved halfword
            r.ok          = 1'b1;
            r.mem_write   = 1'b1;
            r.mem_data    = bp_saved[hit];
            bp_used[hit]  = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Response side: random stall bursts, released while calm is set
    // ------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left   = $urandom_range(1, 13) - 1;
            end
            else
            begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    // every accepted response word is held against the oldest prediction
    always @(posedge clk)
    begin
        bp_rsp_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                $error("unexpected response word: ok %b mem_address %h",
                       rsp_ch.ok, rsp_ch.mem_address);
                mismatches++;
            end
            else
            begin
                want = pending_rsp_q.pop_front();
                check_field("ok", 32'(want.ok), 32'(rsp_ch.ok));
                check_field("mem_write", 32'(want.mem_write), 32'(rsp_ch.mem_write));
                check_field("mem_address", want.mem_address, rsp_ch.mem_address);
                check_field("mem_data", 32'(want.mem_data), 32'(rsp_ch.mem_data));
            end
        end
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Sends one command word. Valid stays high after the handshake until the next
    // call replaces or lowers it, or a drain lowers it, at the following falling edge.
    task automatic send_cmd(logic op, logic [31:0] guest, logic [15:0] halfword);
        bp_cmd_t c;
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap          = $urandom_range(1, 13);
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid            = 1'b1;
        cmd_ch.opcode           = op;
        cmd_ch.guest_addr       = guest;
        cmd_ch.current_halfword = halfword;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        c = '{opcode: op, guest_addr: guest, current_halfword: halfword};
        pending_rsp_q.push_back(apply_breakpoint_cmd(c));
    endtask

    // Holds the command side off until every owed response has come back.
    task automatic drain_responses();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    // APB write followed by a readback of the same register. Only called
    // with the block idle.
    task automatic program_register(logic [sbt_pkg::CFG_ADDR_W-1:0] addr,
                                    logic [31:0] data);
        logic [31:0] want;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == FLASH_BASE_ADDR)
            shadow_flash_base = data;
        else if (addr == RAM_BASE_ADDR)
            shadow_ram_base = data;
        want = (addr == FLASH_BASE_ADDR) ? shadow_flash_base : shadow_ram_base;
        // readback: setup then access, prdata taken with pready
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field("prdata", want, prdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Boundaries of the guest map: bottom and top of flash, both ends of
    // the RAM window, first address past it and the top of the space.
    // Halfwords alternate between all zeros and all ones.
    task automatic test_translation_edges();
        drain_responses();
        program_register(FLASH_BASE_ADDR, 32'h4000_0000);
        program_register(RAM_BASE_ADDR, 32'h2000_0000);
        send_cmd(sbt_pkg::OP_SET, 32'h0000_0000, 16'h0000);
        send_cmd(sbt_pkg::OP_SET, sbt_pkg::RAM_WIN_LO - 1, 16'hFFFF);
        send_cmd(sbt_pkg::OP_SET, sbt_pkg::RAM_WIN_LO, 16'h0000);
        send_cmd(sbt_pkg::OP_SET, sbt_pkg::RAM_WIN_HI - 1, 16'hFFFF);
        send_cmd(sbt_pkg::OP_SET, sbt_pkg::RAM_WIN_HI, 16'h0000);
        send_cmd(sbt_pkg::OP_SET, 32'hFFFF_FFFF, 16'hFFFF);
    endtask

    // Fill the table, overflow it, set a duplicate, clear a missing entry,
    // free two entries and take the lowest one back.
    task automatic test_table_capacity();
        send_cmd(sbt_pkg::OP_SET, 32'h0000_1000, 16'h1234);
        send_cmd(sbt_pkg::OP_SET, 32'h0000_1002, 16'hA5A5);
        send_cmd(sbt_pkg::OP_SET, 32'h0000_1004, 16'h5A5A);          // table full
        send_cmd(sbt_pkg::OP_SET, sbt_pkg::RAM_WIN_LO, 16'h7777);     // already present
        send_cmd(sbt_pkg::OP_CLEAR, 32'h0000_1006, 16'hFFFF);        // not in table
        send_cmd(sbt_pkg::OP_CLEAR, sbt_pkg::RAM_WIN_HI - 1, 16'h0000);
        send_cmd(sbt_pkg::OP_CLEAR, 32'h0000_0000, 16'hFFFF);
        send_cmd(sbt_pkg::OP_SET, 32'h0000_1004, 16'h0F0F);
    endtask

    // Two guest addresses mapping onto one host address hit the same entry.
    task automatic test_address_alias();
        drain_responses();
        program_register(FLASH_BASE_ADDR, 32'h2000_0000);
        send_cmd(sbt_pkg::OP_SET, 32'h0000_0100, 16'hC0DE);
        send_cmd(sbt_pkg::OP_SET, 32'h2000_0100, 16'h1111);          // same host word
        send_cmd(sbt_pkg::OP_CLEAR, 32'h2000_0100, 16'h2222);
    endtask

    // ------------------------------------------------------------------
    // Random phase: commands mostly drawn from a small address pool so the
    // table fills, hits and misses; the rest is arbitrary addresses.
    // ------------------------------------------------------------------
    task automatic run_random_phase(int count, logic [31:0] flash_base,
                                    logic [31:0] ram_base, bit quiet_end);
        logic [31:0] pool [POOL_SIZE];
        logic [31:0] guest;
        logic [31:0] host;
        logic        op;
        int          k;
        drain_responses();
        program_register(FLASH_BASE_ADDR, flash_base);
        program_register(RAM_BASE_ADDR, ram_base);
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            case ($urandom_range(0, 4))
                0: pool[i] = $urandom & 32'h0FFF_FFFF;
                1: pool[i] = sbt_pkg::RAM_WIN_LO + $urandom_range(0, 32'h1FFF);
                2: pool[i] = sbt_pkg::RAM_WIN_HI + $urandom_range(0, 32'hEFFF_DFFF);
                3:
                begin
                    case ($urandom_range(0, 5))
                        0: pool[i] = 32'h0000_0000;
                        1: pool[i] = sbt_pkg::RAM_WIN_LO - 1;
                        2: pool[i] = sbt_pkg::RAM_WIN_LO;
                        3: pool[i] = sbt_pkg::RAM_WIN_HI - 1;
                        4: pool[i] = sbt_pkg::RAM_WIN_HI;
                        default: pool[i] = 32'hFFFF_FFFF;
                    endcase
                end
                default:
                begin
                    // alias of the previous slot where its host address
                    // lies in the pass-through range
                    host    = (i > 0) ? host_of(pool[i-1]) : 32'h0;
                    pool[i] = (host >= sbt_pkg::RAM_WIN_HI) ? host : $urandom;
                end
            endcase
        end
        calm = quiet_end;
        for (int n = 0; n < count; n++)
        begin
            if (!quiet_end && n % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0)
            begin
                k       = $urandom_range(0, POOL_SIZE - 1);
                pool[k] = $urandom;
            end
            if ($urandom_range(0, 99) < 85)
                guest = pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                guest = $urandom;
            op = ($urandom_range(0, 99) < 55) ? sbt_pkg::OP_SET : sbt_pkg::OP_CLEAR;
            send_cmd(op, guest, 16'($urandom));
            // now and then wait for the block to empty out, never at the end
            if (!quiet_end && $urandom_range(0, 59) == 0)
                drain_responses();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        cmd_ch.valid            = 1'b0;
        cmd_ch.opcode           = sbt_pkg::OP_SET;
        cmd_ch.guest_addr       = '0;
        cmd_ch.current_halfword = '0;
        shadow_flash_base       = '0;
        shadow_ram_base         = '0;
        for (int i = 0; i < BP_SLOTS; i++)
        begin
            bp_addr[i]  = '0;
            bp_saved[i] = '0;
            bp_used[i]  = 1'b0;
        end
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_translation_edges();
        test_table_capacity();
        test_address_alias();

        run_random_phase(230, 32'h0000_0000, 32'h0000_0000, 1'b0);
        run_random_phase(230, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        run_random_phase(230, $urandom, $urandom, 1'b0);
        // RAM window lands on the first pass-through address: more aliasing
        run_random_phase(230, 32'h2000_0000, sbt_pkg::RAM_WIN_HI, 1'b0);
        run_random_phase(230, $urandom, $urandom, 1'b0);
        run_random_phase(230, $urandom, 32'hFFFF_F000, 1'b1);

        drain_responses();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_rsp_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
